@@ design/assert_macros.svh @@
// assertion macros shared by the checker files
// both expect i_clk and i_rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside of reset
`define HCPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("hcpe assertion failed");

// consequent must hold in the cycle after the antecedent
`define HCPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcpe assertion failed");

`endif

@@ design/hcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// hcpe_pkg
// Types and constants shared by the 2x2 Hill cipher pair encryptor.
// ----------------------------------------------------------------------------
package hcpe_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned KEY_W  = 5;
    localparam int unsigned PP_W   = 10;  // one product of two residues, at most 625
    localparam int unsigned SUM_W  = 11;  // row sum of two products, at most 1250

    localparam logic [KEY_W-1:0] MOD_VAL = 5'd26;

    // key register reset values
    localparam logic [KEY_W-1:0] KEY_R0C0_RST = 5'd2;
    localparam logic [KEY_W-1:0] KEY_R0C1_RST = 5'd1;
    localparam logic [KEY_W-1:0] KEY_R1C0_RST = 5'd3;
    localparam logic [KEY_W-1:0] KEY_R1C1_RST = 5'd4;

    // register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_R0C0 = 2'd0;
    localparam logic [1:0] REG_R0C1 = 2'd1;
    localparam logic [1:0] REG_R1C0 = 2'd2;
    localparam logic [1:0] REG_R1C1 = 2'd3;

    localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ = 8'h5a;

    typedef struct packed {
        logic [KEY_W-1:0] r0c0;
        logic [KEY_W-1:0] r0c1;
        logic [KEY_W-1:0] r1c0;
        logic [KEY_W-1:0] r1c1;
    } t_key;

    // one queued job: a completed pair, or a lone final byte
    typedef struct packed {
        logic [CHAR_W-1:0] ch0;
        logic [SUM_W-1:0]  sum0;
        logic [CHAR_W-1:0] ch1;
        logic [SUM_W-1:0]  sum1;
        logic              pair;
        logic              last;
    } t_pair;

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_LA) && (c <= CH_LZ);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

endpackage

@@ design/hcpe_front.sv @@
// ----------------------------------------------------------------------------
// hcpe_front
// Accepts text bytes, holds the first byte of each pair with its partial
// products, and pushes completed pairs or a lone final byte to the queue.
// ----------------------------------------------------------------------------
module hcpe_front import hcpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key              i_key,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_eot,
    output logic              o_ready,
    input  logic              i_full,
    output logic              o_push,
    output t_pair             o_entry
);

    logic              r_holding;
    logic [CHAR_W-1:0] r_held_char;
    logic [PP_W-1:0]   r_pp0;
    logic [PP_W-1:0]   r_pp1;

    logic              accept;
    logic [KEY_W-1:0]  res;
    logic [KEY_W-1:0]  ka;
    logic [KEY_W-1:0]  kb;
    logic [PP_W-1:0]   prod_a;
    logic [PP_W-1:0]   prod_b;

    // key value mod 26, keys are at most 31
    function automatic logic [KEY_W-1:0] key_res(input logic [KEY_W-1:0] k);
        return (k >= MOD_VAL) ? k - MOD_VAL : k;
    endfunction

    // value fed into the product, reduced mod 26
    function automatic logic [KEY_W-1:0] char_res(input logic [CHAR_W-1:0] c);
        logic [6:0] y;
        logic [6:0] r;
        // 32 = 6 mod 26
        y = 7'(c[7:5]) * 7'd6 + 7'(c[4:0]);
        if (y >= 7'd52) begin
            r = y - 7'd52;
        end else if (y >= 7'd26) begin
            r = y - 7'd26;
        end else begin
            r = y;
        end
        if (is_lower(c)) begin
            return KEY_W'(c - CH_LA);
        end else if (is_upper(c)) begin
            return KEY_W'(c - CH_UA);
        end
        return r[KEY_W-1:0];
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        res    = char_res(i_char);
        ka     = r_holding ? key_res(i_key.r0c1) : key_res(i_key.r0c0);
        kb     = r_holding ? key_res(i_key.r1c1) : key_res(i_key.r1c0);
        prod_a = PP_W'(ka) * PP_W'(res);
        prod_b = PP_W'(kb) * PP_W'(res);
    end

    assign o_push = accept && (r_holding || i_eot);

    always_comb begin
        o_entry.ch0  = r_holding ? r_held_char : i_char;
        o_entry.sum0 = SUM_W'(prod_a) + (r_holding ? SUM_W'(r_pp0) : '0);
        o_entry.ch1  = i_char;
        o_entry.sum1 = SUM_W'(prod_b) + (r_holding ? SUM_W'(r_pp1) : '0);
        o_entry.pair = r_holding;
        o_entry.last = r_holding ? i_eot : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else if (accept) begin
            r_holding <= !r_holding && !i_eot;
        end
    end

    // first byte of a pair: keep it and its products with column 0
    always_ff @(posedge i_clk) begin
        if (accept && !r_holding) begin
            r_held_char <= i_char;
            r_pp0       <= prod_a;
            r_pp1       <= prod_b;
        end
    end

endmodule

@@ design/hcpe_queue.sv @@
// ----------------------------------------------------------------------------
// hcpe_queue
// Short first-in first-out queue of pair jobs between front and back.
// ----------------------------------------------------------------------------
module hcpe_queue import hcpe_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_entry,
    output logic  o_full,
    input  logic  i_pop,
    output t_pair o_entry,
    output logic  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_pair            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ design/hcpe_back.sv @@
// ----------------------------------------------------------------------------
// hcpe_back
// Takes pair jobs from the queue, reduces each row sum mod 26, restores the
// letter case; its output register emits one cipher byte per cycle if unstalled.
// ----------------------------------------------------------------------------
module hcpe_back import hcpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pair             i_entry,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_half;

    logic              load;
    logic              final_half;
    logic [CHAR_W-1:0] sel_ch;
    logic [SUM_W-1:0]  sel_sum;
    logic [KEY_W-1:0]  sel_res;
    logic [CHAR_W-1:0] n_char;

    // row sum mod 26 by folding: 64 = 12 and 32 = 6 mod 26
    function automatic logic [KEY_W-1:0] sum_mod(input logic [SUM_W-1:0] x);
        logic [8:0] y;
        logic [6:0] z;
        logic [6:0] r;
        y = 9'(x[10:6]) * 9'd12 + 9'(x[5:0]);
        z = 7'(y[8:5]) * 7'd6 + 7'(y[4:0]);
        if (z >= 7'd104) begin
            r = z - 7'd104;
        end else if (z >= 7'd78) begin
            r = z - 7'd78;
        end else if (z >= 7'd52) begin
            r = z - 7'd52;
        end else if (z >= 7'd26) begin
            r = z - 7'd26;
        end else begin
            r = z;
        end
        return r[KEY_W-1:0];
    endfunction

    assign load       = !i_empty && (!r_valid || i_ready);
    assign final_half = r_half || !i_entry.pair;
    assign o_pop      = load && final_half;

    always_comb begin
        sel_ch  = r_half ? i_entry.ch1 : i_entry.ch0;
        sel_sum = r_half ? i_entry.sum1 : i_entry.sum0;
        sel_res = sum_mod(sel_sum);
        if (is_lower(sel_ch)) begin
            n_char = CH_LA + CHAR_W'(sel_res);
        end else if (is_upper(sel_ch)) begin
            n_char = CH_UA + CHAR_W'(sel_res);
        end else begin
            n_char = sel_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= !final_half;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            // first byte of a pair never ends the text
            r_last <= final_half && i_entry.last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

@@ design/hill_cipher_pair_encrypt.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_pair_encrypt
// 2x2 Hill cipher over a byte stream with an APB key register port.
// ----------------------------------------------------------------------------
// Text bytes enter on s_axis one per cycle, with tlast on the final byte of a
// text; cipher bytes leave on m_axis one per cycle, with tlast on the final
// cipher byte. The first byte of a pair is held and gives no output; on the
// second byte the pair job enters a short queue, and its two cipher bytes
// leave in order from the queue through the output register. A text of odd
// length ends with one cipher byte for its lone final byte. The sustained
// rate is one byte per cycle in each direction, set by the output register
// that sends one byte a cycle; s_axis_tready falls only when the queue of
// P_QUEUE_DEPTH pair jobs is full because m_axis is stalled. Keys
// are written at byte addresses 0, 4, 8 and 12 (row 0 column 0, row 0
// column 1, row 1 column 0, row 1 column 1), 5 bits each, and should only
// be changed while the stream is idle.
// ----------------------------------------------------------------------------
module hill_cipher_pair_encrypt import hcpe_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // end_of_text
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] cipher_char
    output logic        m_axis_tlast,   // last_out
    // key register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_key  r_key;
    logic  cfg_wr;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_pair q_in;
    t_pair q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.r0c0 <= KEY_R0C0_RST;
            r_key.r0c1 <= KEY_R0C1_RST;
            r_key.r1c0 <= KEY_R1C0_RST;
            r_key.r1c1 <= KEY_R1C1_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_R0C0: r_key.r0c0 <= pwdata[KEY_W-1:0];
                REG_R0C1: r_key.r0c1 <= pwdata[KEY_W-1:0];
                REG_R1C0: r_key.r1c0 <= pwdata[KEY_W-1:0];
                REG_R1C1: r_key.r1c1 <= pwdata[KEY_W-1:0];
                default:  r_key      <= r_key;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_R0C0: prdata = 32'(r_key.r0c0);
            REG_R0C1: prdata = 32'(r_key.r0c1);
            REG_R1C0: prdata = 32'(r_key.r1c0);
            REG_R1C1: prdata = 32'(r_key.r1c1);
            default:  prdata = '0;
        endcase
    end

    hcpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    hcpe_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty)
    );

    hcpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

@@ design/hcpe_checker.sv @@
// ----------------------------------------------------------------------------
// hcpe_checker
// Port-level checks on the Hill cipher pair encryptor, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcpe_checker import hcpe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic [15:0]      r_pend;
    logic             r_wr_seen;
    logic [1:0]       r_wr_idx;
    logic [KEY_W-1:0] r_wr_val;
    logic             in_acc;
    logic             out_acc;
    logic             out_stall;
    logic             cfg_wr;
    logic             cfg_rd;
    logic             rd_check;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_rd    = psel && !pwrite;
    assign rd_check  = r_wr_seen && cfg_rd && (paddr[3:2] == r_wr_idx);

    // bytes taken in whose cipher byte has not yet been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_wr_seen <= 1'b0;
        end else begin
            r_pend    <= r_pend + 16'(in_acc) - 16'(out_acc);
            r_wr_seen <= cfg_wr;
        end
    end

    // key index and value of the previous cycle's write
    always_ff @(posedge i_clk) begin
        r_wr_idx <= paddr[3:2];
        r_wr_val <= pwdata[KEY_W-1:0];
    end

    // a stalled cipher byte stays offered and unchanged
    `HCPE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))

    // every cipher byte stands for a text byte already taken
    `HCPE_ASSERT(a_out_has_source, !m_axis_tvalid || (r_pend != 16'd0))

    // a key written and read back at once returns its low five bits
    `HCPE_ASSERT(a_cfg_readback, !rd_check || (prdata == 32'(r_wr_val)))

endmodule

bind hill_cipher_pair_encrypt hcpe_checker u_hcpe_checker (.*);
